FILE: src/hufd_pkg.sv
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants for the Huffman code-tree walking decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

   // Node table depth; must be a power of two
   localparam int NODE_ENTRIES = 512;
   localparam int IDX_BITS     = $clog2(NODE_ENTRIES);
   // Width of the remaining-symbol counter
   localparam int COUNT_BITS   = 48;
   // Fixed field widths
   localparam int CSR_BITS     = 48;
   localparam int SYM_BITS     = 8;
   localparam int BIT_IDX_BITS = 3;

   // Request action codes
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_DECODE = 2'd1;
   localparam logic [1:0] ACT_START  = 2'd2;

   // Table read address select
   localparam logic [1:0] RD_ROOT  = 2'd0;
   localparam logic [1:0] RD_WALK  = 2'd1;
   localparam logic [1:0] RD_CHILD = 2'd2;

   // One node table entry
   typedef struct packed {
      logic                is_leaf;
      logic [IDX_BITS-1:0] one_child;
      logic [IDX_BITS-1:0] zero_child;
      logic [SYM_BITS-1:0] sym;
   } node_entry_type;

   localparam int ENTRY_BITS = $bits(node_entry_type);

   // Controller to datapath commands
   typedef struct packed {
      logic                    wr_node;
      logic                    load_byte;
      logic                    start_stream;
      logic                    emit;
      logic                    walk_root;
      logic                    walk_addr;
      logic                    flush;
      logic [1:0]              rd_sel;
      logic [BIT_IDX_BITS-1:0] bit_sel;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_leaf;
      logic count_zero;
   } dp_status_type;

endpackage

FILE: src/hufd_ram.sv
// ----------------------------------------------------------------------------
// hufd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hufd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/hufd_dpath.sv
// ----------------------------------------------------------------------------
// hufd_dpath
// Decoder datapath: node table, walk position, symbol counter, config
// register and the one-deep hold stage that marks the last symbol of a byte.
// ----------------------------------------------------------------------------
module hufd_dpath
   import hufd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [8:0]          req_node_index,
   input  logic                req_node_is_leaf,
   input  logic [8:0]          req_one_child,
   input  logic [8:0]          req_zero_child,
   input  logic [7:0]          req_leaf_symbol,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_wdata,
   output logic                rsp_valid,
   output logic [7:0]          rsp_symbol,
   output logic                rsp_last,
   output logic                rsp_stream_done
);

   logic [CSR_BITS-1:0]   csr_count_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0]   walk_ff, walk_in;
   logic [IDX_BITS-1:0]   raddr_ff, raddr_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SYM_BITS-1:0]   pend_sym_ff, pend_sym_in;
   logic                  pend_done_ff, pend_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYM_BITS-1:0]   rsp_sym_ff, rsp_sym_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_done_ff, rsp_done_in;

   node_entry_type        wr_entry;
   node_entry_type        rd_entry;
   logic [ENTRY_BITS-1:0] ram_rdata;
   logic                  wr_en;
   logic                  cur_bit;

   // node write: out-of-range index ignored, children wrapped
   assign wr_en               = cmd.wr_node && (32'(req_node_index) < NODE_ENTRIES);
   assign wr_entry.is_leaf    = req_node_is_leaf;
   assign wr_entry.one_child  = IDX_BITS'(req_one_child % NODE_ENTRIES);
   assign wr_entry.zero_child = IDX_BITS'(req_zero_child % NODE_ENTRIES);
   assign wr_entry.sym        = req_leaf_symbol;

   hufd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (NODE_ENTRIES)
   ) u_node_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_BITS'(req_node_index)),
      .wr_data (wr_entry),
      .rd_addr (raddr_in),
      .rd_data (ram_rdata)
   );

   assign rd_entry = node_entry_type'(ram_rdata);
   assign cur_bit  = byte_ff[cmd.bit_sel];

   assign status.is_leaf    = rd_entry.is_leaf;
   assign status.count_zero = (count_ff == '0);

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_WALK:  raddr_in = walk_ff;
         RD_CHILD: raddr_in = cur_bit ? rd_entry.one_child : rd_entry.zero_child;
         RD_ROOT:  raddr_in = '0;
         default:  raddr_in = '0;
      endcase
   end

   // walk position, counter and byte
   always_comb begin
      walk_in  = walk_ff;
      count_in = count_ff;
      byte_in  = cmd.load_byte ? req_data_byte : byte_ff;
      if (cmd.start_stream) begin
         walk_in  = '0;
         count_in = COUNT_BITS'(csr_count_ff);
      end
      if (cmd.walk_root) begin
         walk_in = '0;
      end else if (cmd.walk_addr) begin
         walk_in = raddr_ff;
      end
      if (cmd.emit) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   // hold the newest symbol until the next one or the byte end shows if it is last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = 1'b0;
      rsp_sym_in    = pend_sym_ff;
      rsp_last_in   = 1'b0;
      rsp_done_in   = pend_done_ff;
      if (cmd.emit) begin
         rsp_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_sym_in   = rd_entry.sym;
         pend_done_in  = (count_ff == COUNT_BITS'(1));
      end else if (cmd.flush) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff  <= '0;
         count_ff      <= '0;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_count_ff <= csr_wdata;
         end
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      raddr_ff     <= raddr_in;
      byte_ff      <= byte_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol      = rsp_sym_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

FILE: src/hufd_ctrl.sv
// ----------------------------------------------------------------------------
// hufd_ctrl
// Decoder controller: takes requests and steps the tree walk one coded bit
// at a time through the node table read port.
// ----------------------------------------------------------------------------
module hufd_ctrl
   import hufd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_action,
   input  dp_status_type status,
   output logic          busy,
   output dp_cmd_type    cmd
);

   // state codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CUR   = 2'd1;
   localparam logic [1:0] ST_CHILD = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [BIT_IDX_BITS-1:0] bit_ff, bit_in;

   always_comb begin
      cmd      = '0;
      cmd.rd_sel = RD_ROOT;
      state_in = state_ff;
      bit_in   = bit_ff;
      case (state_ff)
         // take a request
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_WRITE: begin
                     cmd.wr_node = 1'b1;
                  end
                  ACT_DECODE: begin
                     cmd.load_byte = 1'b1;
                     cmd.rd_sel    = RD_WALK;
                     bit_in        = '1;
                     state_in      = ST_CUR;
                  end
                  ACT_START: begin
                     cmd.start_stream = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         // read data is the entry at the walk position
         ST_CUR: begin
            if (status.count_zero) begin
               state_in = ST_FLUSH;
            end else if (status.is_leaf) begin
               cmd.emit      = 1'b1;
               cmd.walk_root = 1'b1;
               if (bit_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  bit_in = bit_ff - BIT_IDX_BITS'(1);
               end
            end else begin
               cmd.rd_sel  = RD_CHILD;
               cmd.bit_sel = bit_ff;
               state_in    = ST_CHILD;
            end
         end
         // read data is the child taken for the current bit
         ST_CHILD: begin
            if (status.is_leaf) begin
               cmd.emit      = 1'b1;
               cmd.walk_root = 1'b1;
               if (bit_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  bit_in   = bit_ff - BIT_IDX_BITS'(1);
                  state_in = ST_CUR;
               end
            end else begin
               cmd.walk_addr = 1'b1;
               if (bit_ff == '0) begin
                  state_in = ST_FLUSH;
               end else begin
                  bit_in      = bit_ff - BIT_IDX_BITS'(1);
                  cmd.rd_sel  = RD_CHILD;
                  cmd.bit_sel = bit_ff - BIT_IDX_BITS'(1);
               end
            end
         end
         // release the held symbol as last of the byte
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/huffman_tree_bit_decoder.sv
// Node writes, stream starts and unknown actions complete in the idle state; busy stays low.
// A data byte holds busy while the walk steps through its coded bits, with an extra read
// wherever the walk position is an inner node or the count is spent, then a flush state.
// A symbol shows the cycle after the next one is found; the last in the cycle busy falls.
// No backpressure. Synchronous active-high reset clears the walk, the count and the
// register; the node table keeps its contents and is undefined until written.
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Huffman bit-stream decoder that walks a code tree held in a node table.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder
   import hufd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [8:0]          req_node_index,
   input  logic                req_node_is_leaf,
   input  logic [8:0]          req_one_child,
   input  logic [8:0]          req_zero_child,
   input  logic [7:0]          req_leaf_symbol,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_wdata,
   output logic                rsp_valid,
   output logic [7:0]          rsp_symbol,
   output logic                rsp_last,
   output logic                rsp_stream_done
);

   dp_cmd_type    cmd;
   dp_status_type status;

   hufd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   hufd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_index   (req_node_index),
      .req_node_is_leaf (req_node_is_leaf),
      .req_one_child    (req_one_child),
      .req_zero_child   (req_zero_child),
      .req_leaf_symbol  (req_leaf_symbol),
      .req_data_byte    (req_data_byte),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .rsp_stream_done  (rsp_stream_done)
   );

`ifndef SYNTHESIS
   // a beat only follows a cycle of byte work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without byte in progress");

   // an accepted data byte always starts a walk
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_DECODE) |=> busy)
      else $error("decode byte accepted without walk");

   // the symbol that ends a stream is the last of its byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done) |-> rsp_last)
      else $error("stream end not marked last");

   // busy is already low when the last beat of a byte shows
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy held after last beat");
`endif

endmodule

FILE: bench/tb_huffman_tree_bit_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_bit_decoder
// Self-checking bench for the Huffman code-tree decoder. The low node table
// entries are preloaded as leaves and stray node writes only point there, so
// every walk reads a defined entry. A short scripted sequence then covers the
// edge cases. Random episodes follow: each one sets the symbol count, builds
// a random code tree, starts a stream and decodes random bytes mixed with
// stray beats. Symbols are checked against an in-bench tree walker or script rows.
// ----------------------------------------------------------------------------
module tb_huffman_tree_bit_decoder;
   import hufd_pkg::*;

   // Action code with no meaning to the block
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int RANDOM_BEATS    = 300;
   // Entries preloaded as leaves; stray node writes keep their children below
   localparam int PRELOAD_ENTRIES = 64;
   // Long enough for a decode to drop busy and give its last symbol
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_ROWS     = 24;

   typedef struct packed {
      logic [1:0] action;
      logic [8:0] node_index;
      logic       node_is_leaf;
      logic [8:0] one_child;
      logic [8:0] zero_child;
      logic [7:0] leaf_symbol;
      logic [7:0] data_byte;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
      logic       stream_done;
   } sym_beat_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // One scripted step; typed rows carry their own expected symbols
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_BITS-1:0]   csr_value;
      logic                  typed;
      logic [3:0]            exp_n;
      logic [7:0]            exp_sym;
      logic                  exp_done;
      req_beat_type          beat;
   } script_row_type;

   // Scripted sequence, run right after the table preload
   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      // count still zero after reset: nothing comes out
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'hFF}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_START, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_CSR, 48'd3, 1'b0, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_START, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      // preloaded root is a leaf: one symbol per bit until the count runs out
      '{ROW_BEAT, 48'd0, 1'b1, 4'd3, 8'h00, 1'b1,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      // unknown action
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_UNUSED, 9'h1FF, 1'b1, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF}},
      '{ROW_CSR, 48'hFFFF_FFFF_FFFF, 1'b0, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_START, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      // tree: 1 -> FF, 01 -> 00, 00 -> A5
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd511, 1'b1, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd3, 1'b1, 9'd511, 9'd511, 8'hA5, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd1, 1'b1, 9'd0, 9'd0, 8'hFF, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd2, 1'b0, 9'd511, 9'd3, 8'h33, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd0, 1'b0, 9'd1, 9'd2, 8'h00, 8'h00}},
      // eight one-bit codes: the most a byte can give
      '{ROW_BEAT, 48'd0, 1'b1, 4'd8, 8'hFF, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'hFF}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd4, 8'hA5, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd4, 8'h00, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h55}},
      // mixed codes, ends part way down at entry 2
      '{ROW_BEAT, 48'd0, 1'b0, 4'd0, 8'h00, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'hAA}},
      // turn the current walk position into a leaf
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd2, 1'b1, 9'd0, 9'd0, 8'h5A, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd8, 8'h5A, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h80}},
      // count runs out part way through a byte
      '{ROW_CSR, 48'd2, 1'b0, 4'd0, 8'h00, 1'b0,
        '{ACT_WRITE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_START, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd2, 8'h5A, 1'b1,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'h00}},
      '{ROW_BEAT, 48'd0, 1'b1, 4'd0, 8'h00, 1'b0,
        '{ACT_DECODE, 9'd0, 1'b0, 9'd0, 9'd0, 8'h00, 8'hFF}}
   };

   // Clock, reset and block ports
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_action = ACT_WRITE;
   logic [8:0]          req_node_index = '0;
   logic                req_node_is_leaf = 1'b0;
   logic [8:0]          req_one_child = '0;
   logic [8:0]          req_zero_child = '0;
   logic [7:0]          req_leaf_symbol = '0;
   logic [7:0]          req_data_byte = '0;
   logic                csr_we = 1'b0;
   logic [CSR_BITS-1:0] csr_wdata = '0;
   logic                rsp_valid;
   logic [7:0]          rsp_symbol;
   logic                rsp_last;
   logic                rsp_stream_done;

   // Walker state mirrored in the bench
   node_entry_type        tree_mem [NODE_ENTRIES];
   logic [IDX_BITS-1:0]   walk_pos = '0;
   logic [COUNT_BITS-1:0] syms_left = '0;
   logic [CSR_BITS-1:0]   count_reg = '0;

   sym_beat_type expected_syms [$];
   sym_beat_type step_syms [$];
   int           slot_pool [NODE_ENTRIES-1];
   int           error_count = 0;
   int           cycle_count = 0;
   int           beats_sent = 0;
   logic         no_idle = 1'b0;

   huffman_tree_bit_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_node_index  (req_node_index),
      .req_node_is_leaf(req_node_is_leaf),
      .req_one_child   (req_one_child),
      .req_zero_child  (req_zero_child),
      .req_leaf_symbol (req_leaf_symbol),
      .req_data_byte   (req_data_byte),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol),
      .rsp_last        (rsp_last),
      .rsp_stream_done (rsp_stream_done)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Tree walker: applies one beat, leaves its symbols in step_syms
   function automatic void walk_tree(input req_beat_type beat);
      node_entry_type      cur;
      logic [IDX_BITS-1:0] pos;
      sym_beat_type        hit;
      step_syms.delete();
      case (beat.action)
         ACT_WRITE: begin
            if (beat.node_index < NODE_ENTRIES) begin
               tree_mem[beat.node_index] = '{is_leaf: beat.node_is_leaf,
                                             one_child: beat.one_child,
                                             zero_child: beat.zero_child,
                                             sym: beat.leaf_symbol};
            end
         end
         ACT_START: begin
            syms_left = count_reg;
            walk_pos  = '0;
         end
         ACT_DECODE: begin
            for (int b = 7; b >= 0; b--) begin
               if (syms_left == '0) break;
               pos = walk_pos;
               cur = tree_mem[pos];
               // a leaf sitting at the walk position is taken without a step
               if (!cur.is_leaf) begin
                  pos = beat.data_byte[b] ? cur.one_child : cur.zero_child;
                  cur = tree_mem[pos];
               end
               if (cur.is_leaf) begin
                  syms_left = syms_left - 1'b1;
                  hit = '{symbol: cur.sym, last: 1'b0,
                          stream_done: (syms_left == '0)};
                  step_syms.push_back(hit);
                  walk_pos = '0;
               end else begin
                  walk_pos = pos;
               end
            end
            if (step_syms.size() > 0) step_syms[step_syms.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic req_beat_type random_beat();
      return req_beat_type'({$urandom, $urandom});
   endfunction

   function automatic req_beat_type node_beat(input logic [8:0] idx, input logic leaf,
                                              input logic [8:0] one, input logic [8:0] zero,
                                              input logic [7:0] sym);
      req_beat_type beat;
      beat              = random_beat();
      beat.action       = ACT_WRITE;
      beat.node_index   = idx;
      beat.node_is_leaf = leaf;
      beat.one_child    = one;
      beat.zero_child   = zero;
      beat.leaf_symbol  = sym;
      return beat;
   endfunction

   // Mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [CSR_BITS-1:0] choose_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      if (r < 80) return CSR_BITS'($urandom_range(1, 40));
      return CSR_BITS'({$urandom, $urandom});
   endfunction

   task automatic drive_req(input req_beat_type beat);
      req_action       <= beat.action;
      req_node_index   <= beat.node_index;
      req_node_is_leaf <= beat.node_is_leaf;
      req_one_child    <= beat.one_child;
      req_zero_child   <= beat.zero_child;
      req_leaf_symbol  <= beat.leaf_symbol;
      req_data_byte    <= beat.data_byte;
   endtask

   // Present one beat, wait until it is taken and the block is idle, then queue its symbols
   task automatic send_beat(input req_beat_type beat, input logic typed,
                            input logic [3:0] exp_n, input logic [7:0] exp_sym,
                            input logic exp_done);
      int           gap;
      sym_beat_type want;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
         drive_req(random_beat());
      end
      @(negedge clock);
      start <= 1'b1;
      drive_req(beat);
      do @(posedge clock); while (busy);
      walk_tree(beat);
      if (beat.action != ACT_UNUSED) beats_sent++;
      if (typed) begin
         for (int i = 0; i < exp_n; i++) begin
            want.symbol      = exp_sym;
            want.last        = (i == exp_n - 1);
            want.stream_done = exp_done && (i == exp_n - 1);
            expected_syms.push_back(want);
         end
      end else begin
         foreach (step_syms[i]) expected_syms.push_back(step_syms[i]);
      end
   endtask

   task automatic send_checked(input req_beat_type beat);
      send_beat(beat, 1'b0, 4'd0, 8'h00, 1'b0);
   endtask

   // Drop start, let the block drain, then write the symbol count
   task automatic write_count(input logic [CSR_BITS-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (expected_syms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      count_reg  = value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random full binary tree with the root at entry 0, built bottom up
   task automatic build_tree(input int leaves);
      int roots [$];
      int a, b, pick, idx, tmp, next_slot;
      if (leaves == 1) begin
         send_checked(node_beat(9'd0, 1'b1, 9'($urandom), 9'($urandom), 8'($urandom)));
         return;
      end
      for (int i = 0; i < 2 * leaves - 2; i++) begin
         pick            = $urandom_range(i, NODE_ENTRIES - 2);
         tmp             = slot_pool[i];
         slot_pool[i]    = slot_pool[pick];
         slot_pool[pick] = tmp;
      end
      for (int i = 0; i < leaves; i++) begin
         send_checked(node_beat(9'(slot_pool[i]), 1'b1, 9'($urandom), 9'($urandom),
                                8'($urandom)));
         roots.push_back(slot_pool[i]);
      end
      next_slot = leaves;
      while (roots.size() > 1) begin
         pick = $urandom_range(0, roots.size() - 1);
         a    = roots[pick];
         roots.delete(pick);
         pick = $urandom_range(0, roots.size() - 1);
         b    = roots[pick];
         roots.delete(pick);
         if (roots.size() == 0) begin
            idx = 0;
         end else begin
            idx = slot_pool[next_slot];
            next_slot++;
         end
         send_checked(node_beat(9'(idx), 1'b0, 9'(a), 9'(b), 8'($urandom)));
         roots.push_back(idx);
      end
   endtask

   // One stream: count, tree, start, then bytes with some stray beats
   task automatic run_episode();
      req_beat_type beat;
      int           r;
      no_idle = ($urandom_range(0, 3) == 0);
      write_count(choose_count());
      build_tree(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10));
      beat        = random_beat();
      beat.action = ACT_START;
      send_checked(beat);
      repeat ($urandom_range(6, 24)) begin
         r    = $urandom_range(0, 99);
         beat = random_beat();
         if (r < 80) begin
            beat.action = ACT_DECODE;
         end else if (r < 86) begin
            // stray node write: children stay inside the preloaded entries
            beat.action     = ACT_WRITE;
            beat.one_child  = 9'(beat.one_child % PRELOAD_ENTRIES);
            beat.zero_child = 9'(beat.zero_child % PRELOAD_ENTRIES);
         end else if (r < 91) begin
            beat.action = ACT_UNUSED;
         end else if (r < 95) begin
            beat.action = ACT_START;
         end else begin
            beat.action    = ACT_DECODE;
            beat.data_byte = {8{r[0]}};
         end
         send_checked(beat);
      end
   endtask

   // Symbol checker
   always @(posedge clock) begin
      sym_beat_type want;
      if (!reset && rsp_valid) begin
         if (expected_syms.size() == 0) begin
            $display("%0t ns: symbol %02h with none expected", $time, rsp_symbol);
            error_count++;
         end else begin
            want = expected_syms.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $display("%0t ns: symbol expected %02h, got %02h",
                        $time, want.symbol, rsp_symbol);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t ns: last expected %0b, got %0b",
                        $time, want.last, rsp_last);
               error_count++;
            end
            if (rsp_stream_done !== want.stream_done) begin
               $display("%0t ns: stream_done expected %0b, got %0b",
                        $time, want.stream_done, rsp_stream_done);
               error_count++;
            end
         end
      end
   end

   // Timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      script_row_type row;
      for (int i = 0; i < NODE_ENTRIES - 1; i++) slot_pool[i] = i + 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // low entries become defined leaves; stray node writes point their children at them
      for (int i = 0; i < PRELOAD_ENTRIES; i++) begin
         send_checked(node_beat(9'(i), 1'b1, 9'(~i), 9'(i), 8'(i)));
      end

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = SCRIPT[i];
         if (row.kind == ROW_CSR) begin
            write_count(row.csr_value);
         end else begin
            send_beat(row.beat, row.typed, row.exp_n, row.exp_sym, row.exp_done);
         end
      end

      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) run_episode();

      @(negedge clock);
      start <= 1'b0;
      while (expected_syms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/hufd_pkg.sv
src/hufd_ram.sv
src/hufd_dpath.sv
src/hufd_ctrl.sv
src/huffman_tree_bit_decoder.sv
bench/tb_huffman_tree_bit_decoder.sv
